@@ rtl/bb3_pkg.sv @@
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int CH_W       = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  // The row counter runs two rows past the frame while the last rows drain.
  localparam int ROW_W      = FH_W + 1;
  // Nine 8-bit values plus the rounding half.
  localparam int SUM_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Reciprocals scaled by 2^16; exact for every sum the window can produce.
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_3 = 15'd21846;
  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

  typedef enum logic [1:0] {
    DIV_BY_1,
    DIV_BY_3,
    DIV_BY_9
  } div_sel_t;

  typedef struct packed {
    div_sel_t   sel;
    logic [1:0] shift;
  } div_ctl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t above;
    rgb_t two_above;
  } line_pair_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    logic            command;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            last;
  } out_item_t;

endpackage

@@ rtl/bb3_line_buf.sv @@
`timescale 1ns / 1ps

module bb3_line_buf import bb3_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     rd_req,
  input  logic [$clog2(DEPTH)-1:0] rd_col,
  input  logic                     wr_valid,
  input  logic [$clog2(DEPTH)-1:0] wr_col,
  input  line_pair_t               wr_data,
  output line_pair_t               rd_data
);

  line_pair_t mem_r [DEPTH];
  line_pair_t mem_q_r;
  line_pair_t fwd_r;
  logic       fwd_sel_r;

  // Both rows of a column live in one word. A read of the column being
  // written in the same cycle returns the old word, so that case is
  // forwarded from a register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_valid) begin
        mem_r[wr_col] <= wr_data;
      end
      mem_q_r <= mem_r[rd_col];
      fwd_r   <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (en) begin
      fwd_sel_r <= rd_req && wr_valid && (rd_col == wr_col);
    end
  end

  assign rd_data = fwd_sel_r ? fwd_r : mem_q_r;

endmodule

@@ rtl/bb3_round_div.sv @@
`timescale 1ns / 1ps

module bb3_round_div import bb3_pkg::*; (
  input  logic [SUM_W-1:0] x,
  input  div_ctl_t         ctl,
  output logic [CH_W-1:0]  q
);

  logic [SUM_W-1:0]         y;
  logic [RECIP_W-1:0]       recip;
  logic [SUM_W+RECIP_W-1:0] prod;

  // The power-of-two part of the divisor is a shift, the rest is a
  // multiplication by a scaled reciprocal.
  always_comb begin
    y     = x >> ctl.shift;
    recip = (ctl.sel == DIV_BY_9) ? RECIP_9 : RECIP_3;
    prod  = (SUM_W + RECIP_W)'(y) * (SUM_W + RECIP_W)'(recip);
    unique case (ctl.sel) inside
      DIV_BY_1:           q = y[CH_W-1:0];
      DIV_BY_3, DIV_BY_9: q = prod[RECIP_SHIFT +: CH_W];
      default:            q = y[CH_W-1:0];
    endcase
  end

endmodule

@@ rtl/box_blur_3x3_edge_avg.sv @@
`timescale 1ns / 1ps
// Pipeline: the line memory read is launched at the edge that accepts a transaction;
// its result goes through window update, masked sum and divide to the output register.
// Throughput: one input transaction per clock while cfg_valid is low; the line memory
// reads and writes in the same cycle, so only a result held by out_ready low stalls
// the pipeline.
// Reset (rst_n low at a rising edge) clears the counters, the window, all pipeline
// valids and sets the frame to 640 x 480; the line memory is not cleared.

module box_blur_3x3_edge_avg import bb3_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,

  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WW > FW_W) ? WW : FW_W;

  // Configuration registers.
  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;

  // Position of the next place in the frame.
  logic [AW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  // The 3x3 window: index row*3+col, column 2 is the newest.
  rgb_t             window_r [9];
  rgb_t             window_nxt [9];

  // Stage 1: line memory read in flight.
  logic             s1_v_r;
  logic             s1_clear_r;
  logic             s1_produce_r;
  logic             s1_last_r;
  border_t          s1_border_r;
  rgb_t             s1_pix_r;
  logic [AW-1:0]    s1_col_r;

  // Stage 2: window holds this item's neighborhood.
  logic             s2_v_r;
  logic             s2_last_r;
  border_t          s2_border_r;

  // Stage 3: rounded sums waiting for the divide.
  logic             s3_v_r;
  logic             s3_last_r;
  div_ctl_t         s3_ctl_r;
  logic [SUM_W-1:0] s3_x_r [3];

  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             en;
  logic             in_accept;
  logic             cfg_write;

  // Effective frame size.
  logic [CMP_W-1:0] fw_ext;
  logic [WW-1:0]    w_used;
  logic [AW-1:0]    w_last;
  logic [FH_W-1:0]  h_used;
  logic [ROW_W-1:0] h_ext;

  // Decode of the incoming transaction.
  logic             is_pix;
  logic             is_drain;
  logic             frame_done;
  logic             drain_ok;
  logic             step;
  logic             restart;
  logic [ROW_W-1:0] row_eff;
  logic [AW-1:0]    col_eff;
  logic             produce;
  logic [ROW_W-1:0] out_row;
  logic [AW-1:0]    out_col;
  border_t          border;
  logic [AW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_nxt;
  rgb_t             pix;

  line_pair_t       lb_rd;
  line_pair_t       lb_wr;

  // Sum stage.
  logic [2:0]       row_use;
  logic [2:0]       col_use;
  logic [1:0]       rows_n;
  logic [1:0]       cols_n;
  logic [SUM_W-1:0] sum [3];
  logic [2:0]       half;
  div_ctl_t         div_ctl;
  logic [CH_W-1:0]  quot [3];

  // The whole pipeline advances together whenever the output register is
  // free or being emptied. A configuration transaction takes priority
  // over an input transaction in the same cycle.
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign cfg_write = cfg_valid && cfg_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The width is clamped to what the line memory holds; zero counts as one.
  always_comb begin
    fw_ext = CMP_W'(frame_width_r);
    if (fw_ext == '0) begin
      w_used = WW'(1);
    end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
      w_used = WW'(MAX_WIDTH);
    end else begin
      w_used = WW'(fw_ext);
    end
    w_last = AW'(w_used - WW'(1));
    h_used = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
    h_ext  = ROW_W'(h_used);
  end

  // Place bookkeeping. Once every pixel is in (row at the frame height),
  // drain transactions push empty places until the last output has left,
  // which is place zero of the row after that. A pixel arriving after the
  // frame is complete starts the next frame at place zero.
  always_comb begin
    is_pix     = (in_data.command == CMD_PIXEL);
    is_drain   = (in_data.command == CMD_DRAIN);
    frame_done = (row_r >= h_ext);
    drain_ok   = (row_r == h_ext) || ((row_r == h_ext + ROW_W'(1)) && (col_r == '0));
    step       = is_pix || (is_drain && drain_ok);
    restart    = is_pix && frame_done;
    row_eff    = restart ? '0 : row_r;
    col_eff    = restart ? '0 : col_r;

    // The output trails the incoming place by one row and one pixel.
    produce = (row_eff >= ROW_W'(2)) || ((row_eff == ROW_W'(1)) && (col_eff != '0));
    if (col_eff != '0) begin
      out_row = row_eff - ROW_W'(1);
      out_col = col_eff - AW'(1);
    end else begin
      out_row = row_eff - ROW_W'(2);
      out_col = w_last;
    end
    border.top    = (out_row == '0);
    border.bottom = (out_row == h_ext - ROW_W'(1));
    border.left   = (out_col == '0);
    border.right  = (out_col == w_last);

    if (col_eff == w_last) begin
      col_nxt = '0;
      row_nxt = row_eff + ROW_W'(1);
    end else begin
      col_nxt = col_eff + AW'(1);
      row_nxt = row_eff;
    end

    pix.red   = is_pix ? in_data.in_red   : '0;
    pix.green = is_pix ? in_data.in_green : '0;
    pix.blue  = is_pix ? in_data.in_blue  : '0;
  end

  bb3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .rd_req   (in_accept && step),
    .rd_col   (col_eff),
    .wr_valid (s1_v_r),
    .wr_col   (s1_col_r),
    .wr_data  (lb_wr),
    .rd_data  (lb_rd)
  );

  // The column moves down one row in the line memory.
  assign lb_wr.above     = s1_pix_r;
  assign lb_wr.two_above = lb_rd.above;

  // Shift the window left and bring in the new column. A restarting pixel
  // shifts into an empty window.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 2; c++) begin
        window_nxt[r*3 + c] = s1_clear_r ? '0 : window_r[r*3 + c + 1];
      end
    end
    window_nxt[2] = lb_rd.two_above;
    window_nxt[5] = lb_rd.above;
    window_nxt[8] = s1_pix_r;
  end

  // Masked sums over the neighbors that lie inside the frame.
  always_comb begin
    row_use = {!s2_border_r.bottom, 1'b1, !s2_border_r.top};
    col_use = {!s2_border_r.right, 1'b1, !s2_border_r.left};
    rows_n  = 2'd1 + 2'(!s2_border_r.top) + 2'(!s2_border_r.bottom);
    cols_n  = 2'd1 + 2'(!s2_border_r.left) + 2'(!s2_border_r.right);
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_use[r] && col_use[c]) begin
          sum[0] = sum[0] + SUM_W'(window_r[r*3 + c].red);
          sum[1] = sum[1] + SUM_W'(window_r[r*3 + c].green);
          sum[2] = sum[2] + SUM_W'(window_r[r*3 + c].blue);
        end
      end
    end

    // Divisor is rows times columns: 1, 2, 3, 4, 6 or 9, split into a
    // shift and a factor of one, three or nine.
    unique case ({rows_n, cols_n}) inside
      {2'd1, 2'd1}: begin
        half = 3'd0; div_ctl.shift = 2'd0; div_ctl.sel = DIV_BY_1;
      end
      {2'd1, 2'd2}, {2'd2, 2'd1}: begin
        half = 3'd1; div_ctl.shift = 2'd1; div_ctl.sel = DIV_BY_1;
      end
      {2'd2, 2'd2}: begin
        half = 3'd2; div_ctl.shift = 2'd2; div_ctl.sel = DIV_BY_1;
      end
      {2'd1, 2'd3}, {2'd3, 2'd1}: begin
        half = 3'd1; div_ctl.shift = 2'd0; div_ctl.sel = DIV_BY_3;
      end
      {2'd2, 2'd3}, {2'd3, 2'd2}: begin
        half = 3'd3; div_ctl.shift = 2'd1; div_ctl.sel = DIV_BY_3;
      end
      {2'd3, 2'd3}: begin
        half = 3'd4; div_ctl.shift = 2'd0; div_ctl.sel = DIV_BY_9;
      end
      default: begin
        half = 3'd0; div_ctl.shift = 2'd0; div_ctl.sel = DIV_BY_1;
      end
    endcase
  end

  bb3_round_div u_div_red   (.x(s3_x_r[0]), .ctl(s3_ctl_r), .q(quot[0]));
  bb3_round_div u_div_green (.x(s3_x_r[1]), .ctl(s3_ctl_r), .q(quot[1]));
  bb3_round_div u_div_blue  (.x(s3_x_r[2]), .ctl(s3_ctl_r), .q(quot[2]));

  // Control state: configuration, counters, window and pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      if (en) begin
        s1_v_r      <= in_accept && step;
        s2_v_r      <= s1_v_r && s1_produce_r;
        s3_v_r      <= s2_v_r;
        out_valid_r <= s3_v_r;
        if (s1_v_r) begin
          window_r <= window_nxt;
        end
      end
      if (in_accept && step) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      // A width or height write restarts the frame; the block must be idle then, which it does not enforce.
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH: begin
            frame_width_r <= cfg_data[FW_W-1:0];
            col_r         <= '0;
            row_r         <= '0;
            for (int i = 0; i < 9; i++) begin
              window_r[i] <= '0;
            end
          end
          CFG_FRAME_HEIGHT: begin
            frame_height_r <= cfg_data[FH_W-1:0];
            col_r          <= '0;
            row_r          <= '0;
            for (int i = 0; i < 9; i++) begin
              window_r[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_clear_r   <= restart;
      s1_produce_r <= produce;
      s1_last_r    <= border.bottom && border.right;
      s1_border_r  <= border;
      s1_pix_r     <= pix;
      s1_col_r     <= col_eff;

      s2_last_r    <= s1_last_r;
      s2_border_r  <= s1_border_r;

      s3_last_r    <= s2_last_r;
      s3_ctl_r     <= div_ctl;
      for (int ch = 0; ch < 3; ch++) begin
        s3_x_r[ch] <= sum[ch] + SUM_W'(half);
      end

      out_data_r.out_red   <= quot[0];
      out_data_r.out_green <= quot[1];
      out_data_r.out_blue  <= quot[2];
      out_data_r.last      <= s3_last_r;
    end
  end

  // The column counter always stays inside the effective width.
  a_col_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last)
    else $error("column counter beyond frame width");

  // The row counter never runs more than two rows past the frame.
  a_row_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= h_ext + ROW_W'(2))
    else $error("row counter beyond drain limit");

  // The frame's final output is always the bottom-right pixel.
  a_last_corner : assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_last_r) |-> (s2_border_r.bottom && s2_border_r.right))
    else $error("last flag on a pixel that is not the bottom-right corner");

  // A stall with no register write leaves window entries 4 and 8 untouched.
  a_window_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!en && !cfg_write) |=> $stable(window_r[4]) && $stable(window_r[8]))
    else $error("window changed during a stall");

endmodule

@@ tb/sv/box_blur_3x3_edge_avg_tb.sv @@
`timescale 1ns / 1ps

module box_blur_3x3_edge_avg_tb;
  import bb3_pkg::*;

  localparam int MAX_W = 1024;
  // Margin that settle() waits after the last predicted result has been taken.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_LIMIT = 40;

  // Register indexes that the block must ignore.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_3x3_edge_avg #(
    .MAX_WIDTH(MAX_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idling controls. The sender skips cycles, each with chance idle_pct percent, before
  // each transaction, and the receiver drops ready with probability stall_pct percent.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned drains_sent = 0;
  int unsigned results_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Blur predictor. It keeps its own copy of the frame registers, the two line
  // stores, the 3x3 window and the raster position, and queues the blurred pixel
  // that each accepted transaction should produce.
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_reg;
  logic [FH_W-1:0] frame_height_reg;
  rgb_t above_mem [MAX_W];
  rgb_t two_above_mem [MAX_W];
  rgb_t win [9];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned sent_cnt;
  out_item_t blurred_q [$];

  // The width in use is clamped to 1..MAX_W, and a zero height counts as one row.
  function automatic int unsigned eff_width();
    if (frame_width_reg == 0) return 1;
    if (frame_width_reg > MAX_W) return MAX_W;
    return frame_width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (frame_height_reg == 0) ? 1 : frame_height_reg;
  endfunction

  function automatic void restart_frame();
    foreach (win[k]) win[k] = '0;
    col_pos = 0;
    row_pos = 0;
    sent_cnt = 0;
  endfunction

  function automatic void predictor_reset();
    frame_width_reg = FRAME_WIDTH_RST;
    frame_height_reg = FRAME_HEIGHT_RST;
    foreach (above_mem[k]) begin
      above_mem[k] = '0;
      two_above_mem[k] = '0;
    end
    restart_frame();
  endfunction

  function automatic void predict_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_FRAME_WIDTH) begin
      frame_width_reg = value[FW_W-1:0];
      restart_frame();
    end else if (idx == CFG_FRAME_HEIGHT) begin
      frame_height_reg = value[FH_W-1:0];
      restart_frame();
    end
  endfunction

  function automatic void predict_blur(in_item_t item);
    int unsigned w, h, total, place, c, cr, cc, n;
    int unsigned acc_r, acc_g, acc_b;
    int r, dr, dc;
    rgb_t pix;
    out_item_t res;
    w = eff_width();
    h = eff_height();
    total = w * h;
    place = row_pos * w + col_pos;
    if (item.command == CMD_PIXEL) begin
      // A pixel that arrives after a complete frame opens the next frame, and any
      // outputs of the old frame that were not drained are lost.
      if (place >= total) begin
        restart_frame();
        place = 0;
      end
      pix.red = item.in_red;
      pix.green = item.in_green;
      pix.blue = item.in_blue;
    end else begin
      // A drain only counts once the frame is complete and outputs are still owed.
      if (place < total || sent_cnt >= total) return;
      pix = '0;
    end
    c = (col_pos >= w) ? w - 1 : col_pos;
    for (r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = two_above_mem[c];
    win[5] = above_mem[c];
    win[8] = pix;
    two_above_mem[c] = above_mem[c];
    above_mem[c] = pix;
    if (place >= w + 1) begin
      // The window center trails the incoming place by one row and one column.
      if (c >= 1) begin
        cr = row_pos - 1;
        cc = c - 1;
      end else begin
        cr = row_pos - 2;
        cc = w - 1;
      end
      n = 0;
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
      for (dr = 0; dr < 3; dr++) begin
        for (dc = 0; dc < 3; dc++) begin
          if ((dr == 0 && cr == 0) || (dr == 2 && cr + 1 >= h)) continue;
          if ((dc == 0 && cc == 0) || (dc == 2 && cc + 1 >= w)) continue;
          acc_r += win[dr * 3 + dc].red;
          acc_g += win[dr * 3 + dc].green;
          acc_b += win[dr * 3 + dc].blue;
          n++;
        end
      end
      if (n == 0) n = 1;
      // Round half up.
      res.out_red = CH_W'((acc_r + n / 2) / n);
      res.out_green = CH_W'((acc_g + n / 2) / n);
      res.out_blue = CH_W'((acc_b + n / 2) / n);
      sent_cnt++;
      res.last = (sent_cnt == total);
      blurred_q.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every result transaction is matched against the oldest
  // queued prediction, one field at a time.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    error_count++;
  endtask

  out_item_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (blurred_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = blurred_q.pop_front();
        results_checked++;
        if (out_data.out_red !== want.out_red)
          report_mismatch($sformatf("red %h, expected %h", out_data.out_red, want.out_red));
        if (out_data.out_green !== want.out_green)
          report_mismatch($sformatf("green %h, expected %h", out_data.out_green,
                                    want.out_green));
        if (out_data.out_blue !== want.out_blue)
          report_mismatch($sformatf("blue %h, expected %h", out_data.out_blue,
                                    want.out_blue));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_data.last, want.last));
        if (want.last) frames_closed++;
      end
    end
  end

  // The receiver drops ready at random; with stall_pct at zero it never stalls.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog. A hang anywhere in the run ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
               blurred_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left just after a rising edge.
  // ---------------------------------------------------------------------------
  function automatic logic [CH_W-1:0] rand_channel();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return CH_W'($urandom);
  endfunction

  function automatic in_item_t pixel_item(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                          logic [CH_W-1:0] b);
    in_item_t item;
    item.command = CMD_PIXEL;
    item.in_red = r;
    item.in_green = g;
    item.in_blue = b;
    return item;
  endfunction

  function automatic in_item_t random_pixel();
    return pixel_item(rand_channel(), rand_channel(), rand_channel());
  endfunction

  // The color fields of a drain carry random junk; the block must ignore them.
  function automatic in_item_t drain_item();
    in_item_t item;
    item = in_item_t'($urandom);
    item.command = CMD_DRAIN;
    return item;
  endfunction

  // Sends one transaction. Valid stays high from the previous transaction unless
  // the sender decides to idle first, so back-to-back transfers really happen.
  task automatic send_item(in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data <= in_item_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_blur(item);
    if (item.command == CMD_PIXEL) pixels_sent++;
    else drains_sent++;
  endtask

  // Stops the sender and waits until every predicted result has been taken, then
  // lets the pipeline run empty of transactions that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    predict_config(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the frame is 640 x 480. A drain before the frame is complete is
  // ignored, and a single pixel produces nothing; the next register write drops it.
  task automatic test_reset_defaults();
    send_item(drain_item());
    send_item(pixel_item('1, '1, '1));
  endtask

  // A 3x3 frame with full-scale red and green covers every border case: corners divide
  // by four, edges by six and the center by nine.
  task automatic test_small_frame();
    int k;
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
    for (k = 0; k < 9; k++) begin
      send_item(pixel_item((k % 2) ? '0 : '1, (k % 2) ? '1 : '0,
                           (k == 4) ? CH_W'(255) : CH_W'(k * 30)));
    end
    // Four drains flush the frame; the fifth finds nothing pending.
    repeat (5) send_item(drain_item());
    // A pixel after the completed frame opens a new one.
    send_item(pixel_item('1, '0, '1));
  endtask

  // Zero width and height both behave as one, so the frame is a single pixel
  // averaged with nothing but itself. The width write also carries set upper bits.
  task automatic test_degenerate_sizes();
    write_reg(CFG_FRAME_WIDTH, 16'hF800);
    write_reg(CFG_FRAME_HEIGHT, '0);
    send_item(pixel_item(8'hA5, 8'h5A, 8'hFF));
    repeat (3) send_item(drain_item());
  endtask

  // Writes to unused indexes must neither change a register nor restart the
  // frame, so a 2x2 frame is split around them.
  task automatic test_unused_index();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(2));
    send_item(pixel_item(8'h01, 8'hFE, 8'h80));
    send_item(pixel_item(8'hFF, 8'h00, 8'h7F));
    write_reg(CFG_UNUSED_2, '1);
    write_reg(CFG_UNUSED_3, CFG_DATA_W'(1));
    send_item(pixel_item(8'h10, 8'hEF, 8'h00));
    send_item(pixel_item(8'hC3, 8'h3C, 8'hFF));
    repeat (3) send_item(drain_item());
  endtask

  // Register extremes. A width of 2047 is clamped to the line store size, which
  // only shows up once more than a full row has gone through; a few drains bring
  // out the first results and the register write that follows drops the rest. The
  // tallest frame is streamed in part only, first at the full width and then narrow
  // enough to give results that never reach the bottom border.
  task automatic test_extreme_sizes();
    idle_pct = 37;
    stall_pct = 37;
    write_reg(CFG_FRAME_WIDTH, '1);
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
    repeat (MAX_W) send_item(random_pixel());
    repeat (8) send_item(drain_item());
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MAX_W));
    write_reg(CFG_FRAME_HEIGHT, '1);
    repeat (8) send_item(random_pixel());
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    repeat (30) send_item(random_pixel());
  endtask

  // Random frames. Most are streamed whole and drained, with ignored drains mixed
  // in. Some have their drain cut short by the next frame's first pixel, and some
  // stop partway and are abandoned through a register write.
  task automatic test_random_frames(int unsigned pixel_budget, int unsigned idle,
                                    int unsigned stall);
    int unsigned start_pixels, w, h, mode, npix, ndrain, k;
    bit need_write, keep_dims;
    idle_pct = idle;
    stall_pct = stall;
    start_pixels = pixels_sent;
    need_write = 1'b1;
    keep_dims = 1'b0;
    w = 1;
    h = 1;
    while (pixels_sent - start_pixels < pixel_budget) begin
      if (!keep_dims && (need_write || $urandom_range(1) == 0)) begin
        w = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 40);
        h = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
        // Bits above the width field are random and must be dropped.
        write_reg(CFG_FRAME_WIDTH, (CFG_DATA_W'($urandom) & 16'hF800) | CFG_DATA_W'(w));
        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
      end
      need_write = 1'b0;
      keep_dims = 1'b0;
      mode = $urandom_range(99);
      npix = (mode >= 88 && w * h > 1) ? $urandom_range(1, w * h - 1) : w * h;
      for (k = 0; k < npix; k++) begin
        if ($urandom_range(19) == 0) send_item(drain_item());
        send_item(random_pixel());
      end
      if (mode < 75) begin
        ndrain = w + 1 + $urandom_range(2);
      end else if (mode < 88) begin
        ndrain = $urandom_range(w);
        keep_dims = 1'b1;
      end else begin
        ndrain = 0;
        need_write = 1'b1;
      end
      repeat (ndrain) send_item(drain_item());
      // Now and then the sender holds off until every result is back.
      if ($urandom_range(7) == 0) settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    predictor_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_defaults();
    test_small_frame();
    test_degenerate_sizes();
    test_unused_index();
    test_extreme_sizes();
    test_random_frames(120, 0, 0);
    test_random_frames(120, 65, 0);
    test_random_frames(120, 0, 65);
    test_random_frames(120, 37, 37);

    settle();
    repeat (20) @(posedge clk);

    $display("Streamed %0d pixel and %0d drain transactions; %0d frames ran to their last",
             pixels_sent, drains_sent, frames_closed);
    $display("output, %0d blurred pixels were checked and %0d mismatches found.",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bb3_pkg.sv
rtl/bb3_line_buf.sv
rtl/bb3_round_div.sv
rtl/box_blur_3x3_edge_avg.sv
tb/sv/box_blur_3x3_edge_avg_tb.sv
